/* sv/csvt_pkg.sv */
`default_nettype none

package csvt_pkg;

  // Delimiter and quote characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // One text byte as it enters the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  // One token result as it leaves the parser
  typedef struct packed {
    logic [7:0] content_byte;
    logic       content_valid;
    logic       field_end;
    logic       record_end;
  } result_t;

endpackage

`default_nettype wire

/* sv/csvt_in_if.sv */
`default_nettype none

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

/* sv/csvt_out_if.sv */
`default_nettype none

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] content_byte;
  logic       content_valid;
  logic       field_end;
  logic       record_end;

  modport source (output valid, output content_byte, output content_valid,
                  output field_end, output record_end, input ready);
  modport sink   (input valid, input content_byte, input content_valid,
                  input field_end, input record_end, output ready);
endinterface

`default_nettype wire

/* sv/csvt_in_stage.sv */
`default_nettype none

module csvt_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  csvt_in_if.sink                in_i,
  input  wire logic              take_i,
  output logic                   valid_o,
  output csvt_pkg::in_item_t     item_o
);

  logic                 valid_q;
  csvt_pkg::in_item_t   item_q;
  logic                 load;

  // Accept when empty or when the held byte moves on this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Capture the byte on transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte   <= in_i.data_byte;
      item_q.end_of_text <= in_i.end_of_text;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* sv/csvt_parser.sv */
`default_nettype none

module csvt_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire csvt_pkg::in_item_t item_i,
  output csvt_pkg::result_t       result_o
);

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_AFTERQ = 2'd3;

  logic [1:0] mode_q, mode_d;
  logic       cr_pending_q, cr_pending_d;
  logic       field_bytes_q, field_bytes_d;
  logic       record_fields_q, record_fields_d;

  logic [7:0] b;
  logic       swallow;
  logic       cv, fe, re;

  assign b       = item_i.data_byte;
  // Drop the LF of a CRLF pair
  assign swallow = cr_pending_q && (b == csvt_pkg::CH_LF);

  // Next state and result for one byte
  always_comb begin
    mode_d          = mode_q;
    cr_pending_d    = 1'b0;
    field_bytes_d   = field_bytes_q;
    record_fields_d = record_fields_q;
    cv              = 1'b0;
    fe              = 1'b0;
    re              = 1'b0;

    if (!swallow) begin
      if (mode_q == MODE_QUOTED) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          mode_d = MODE_AFTERQ;
        end else begin
          cv = 1'b1;
        end
      end else if (mode_q == MODE_START && b == csvt_pkg::CH_QUOTE) begin
        mode_d = MODE_QUOTED;
      end else if (mode_q == MODE_AFTERQ && b == csvt_pkg::CH_QUOTE) begin
        // Doubled quote: literal quote, back inside quotes
        mode_d = MODE_QUOTED;
        cv     = 1'b1;
      end else if (b == csvt_pkg::CH_COMMA) begin
        fe              = 1'b1;
        field_bytes_d   = 1'b0;
        record_fields_d = 1'b1;
        mode_d          = MODE_START;
      end else if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
        fe              = 1'b1;
        re              = 1'b1;
        field_bytes_d   = 1'b0;
        record_fields_d = 1'b0;
        cr_pending_d    = (b == csvt_pkg::CH_CR);
        mode_d          = MODE_START;
      end else begin
        mode_d = MODE_PLAIN;
        cv     = 1'b1;
      end
      if (cv) begin
        field_bytes_d = 1'b1;
      end
    end

    // Flush on the final byte, then return to reset values
    if (item_i.end_of_text) begin
      if (field_bytes_d) begin
        fe = 1'b1;
      end
      if (field_bytes_d || record_fields_d) begin
        re = 1'b1;
      end
      mode_d          = MODE_START;
      cr_pending_d    = 1'b0;
      field_bytes_d   = 1'b0;
      record_fields_d = 1'b0;
    end
  end

  // Advance parse state once per byte handed downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_START;
      cr_pending_q    <= 1'b0;
      field_bytes_q   <= 1'b0;
      record_fields_q <= 1'b0;
    end else if (advance_i) begin
      mode_q          <= mode_d;
      cr_pending_q    <= cr_pending_d;
      field_bytes_q   <= field_bytes_d;
      record_fields_q <= record_fields_d;
    end
  end

  assign result_o.content_byte  = cv ? b : 8'h00;
  assign result_o.content_valid = cv;
  assign result_o.field_end     = fe;
  assign result_o.record_end    = re;

  // A pending CR only follows a completed record
  a_cr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_pending_q |-> (mode_q == MODE_START) && !field_bytes_q && !record_fields_q)
    else $error("cr_pending set with record or field open");

  // The final byte leaves the parser in its reset state
  a_flush_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.end_of_text |=>
      (mode_q == MODE_START) && !cr_pending_q && !field_bytes_q && !record_fields_q)
    else $error("state not cleared after end of text");

  // A record end needs a field end now or a completed field before
  a_record_has_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && re |-> fe || record_fields_q)
    else $error("empty record ended");

  // Content mid-text marks the field as holding bytes
  a_content_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && cv && !item_i.end_of_text |=> field_bytes_q)
    else $error("content byte not recorded in field");

endmodule

`default_nettype wire

/* sv/csvt_out_stage.sv */
`default_nettype none

module csvt_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire csvt_pkg::result_t result_i,
  output logic                   ready_o,
  csvt_out_if.source             out_o
);

  logic                valid_q;
  csvt_pkg::result_t   result_q;

  // Take a new result when empty or when the held one transfers
  assign ready_o = !valid_q || out_o.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result until it transfers
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.content_byte  = result_q.content_byte;
  assign out_o.content_valid = result_q.content_valid;
  assign out_o.field_end     = result_q.field_end;
  assign out_o.record_end    = result_q.record_end;

endmodule

`default_nettype wire

/* sv/csv_tokenizer.sv */
// CSV tokenizer: takes one text byte per transfer and returns one token result per
// byte, in order, marking content bytes, field ends and record ends (comma ends a
// field; CR, LF or CRLF ends a record; quotes group text and a doubled quote is a
// literal quote). It sustains one byte per cycle while the output is ready; each byte
// passes an input register, then the parse state update and an output register. The
// rate is set by the parse state loop. Assert end_of_text on the last byte of a
// text to flush the open field and record and return the parser to its reset state.
`default_nettype none

module csv_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csvt_in_if.sink   in_i,
  csvt_out_if.source out_o
);

  logic                s1_valid;
  csvt_pkg::in_item_t  s1_item;
  csvt_pkg::result_t   s1_result;
  logic                s2_ready;
  logic                advance;

  // Byte moves from input register into the result register
  assign advance = s1_valid && s2_ready;

  csvt_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (advance),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  csvt_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item),
    .result_o  (s1_result)
  );

  csvt_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .result_i (s1_result),
    .ready_o  (s2_ready),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

/* dv/tb_csv_tokenizer.sv */
`default_nettype none

module tb_csv_tokenizer;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          PHASE_BYTES  = 360;
  localparam int          DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_AFTERQ = 2'd3
  } parse_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csvt_in_if  in_if ();
  csvt_out_if out_if ();

  csv_tokenizer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Text bytes waiting to be sent, and tokens predicted for accepted bytes
  csvt_pkg::in_item_t text_bytes_q[$];
  csvt_pkg::result_t  token_expect_q[$];
  logic [7:0]         build_q[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          phase_bytes;
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Parser state mirrored by the predictor
  parse_mode_e tok_mode = MODE_START;
  logic        cr_pend = 1'b0;
  logic        fld_bytes = 1'b0;
  logic        rec_fields = 1'b0;

  csvt_pkg::in_item_t next_byte;
  csvt_pkg::result_t  want_tok;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Advance the mirrored parser by one byte and return the token it emits
  function automatic csvt_pkg::result_t predict_token(logic [7:0] b, logic last);
    csvt_pkg::result_t tok;
    logic    swallow;
    logic    cv;
    logic    fe;
    logic    re;
    cv = 1'b0;
    fe = 1'b0;
    re = 1'b0;
    swallow = cr_pend && (b == csvt_pkg::CH_LF);
    cr_pend = 1'b0;
    if (!swallow) begin
      if (tok_mode == MODE_QUOTED) begin
        if (b == csvt_pkg::CH_QUOTE) tok_mode = MODE_AFTERQ;
        else cv = 1'b1;
      end else if (tok_mode == MODE_START && b == csvt_pkg::CH_QUOTE) begin
        tok_mode = MODE_QUOTED;
      end else if (tok_mode == MODE_AFTERQ && b == csvt_pkg::CH_QUOTE) begin
        tok_mode = MODE_QUOTED;
        cv = 1'b1;
      end else if (b == csvt_pkg::CH_COMMA) begin
        fe = 1'b1;
        fld_bytes = 1'b0;
        rec_fields = 1'b1;
        tok_mode = MODE_START;
      end else if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
        fe = 1'b1;
        re = 1'b1;
        fld_bytes = 1'b0;
        rec_fields = 1'b0;
        cr_pend = (b == csvt_pkg::CH_CR);
        tok_mode = MODE_START;
      end else begin
        tok_mode = MODE_PLAIN;
        cv = 1'b1;
      end
      if (cv) fld_bytes = 1'b1;
    end
    // Flush the open field and record on the final byte, then start over
    if (last) begin
      if (fld_bytes) begin
        fe = 1'b1;
        rec_fields = 1'b1;
      end
      if (rec_fields) re = 1'b1;
      tok_mode = MODE_START;
      cr_pend = 1'b0;
      fld_bytes = 1'b0;
      rec_fields = 1'b0;
    end
    tok.content_byte  = cv ? b : 8'h00;
    tok.content_valid = cv;
    tok.field_end     = fe;
    tok.record_end    = re;
    return tok;
  endfunction

  // Driver: hold a byte until its transfer, predict on every transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.data_byte   <= 8'h00;
      in_if.end_of_text <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        token_expect_q = {token_expect_q,
                          predict_token(in_if.data_byte, in_if.end_of_text)};
      if (!in_if.valid || in_if.ready) begin
        if (text_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = text_bytes_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.data_byte   <= next_byte.data_byte;
          in_if.end_of_text <= next_byte.end_of_text;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each token transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (token_expect_q.size() == 0) begin
          report_mismatch("token with no byte outstanding", out_if.content_byte, 8'h00);
        end else begin
          want_tok = token_expect_q.pop_front();
          if (out_if.content_byte !== want_tok.content_byte)
            report_mismatch("content_byte", out_if.content_byte, want_tok.content_byte);
          if (out_if.content_valid !== want_tok.content_valid)
            report_mismatch("content_valid", 8'(out_if.content_valid),
                            8'(want_tok.content_valid));
          if (out_if.field_end !== want_tok.field_end)
            report_mismatch("field_end", 8'(out_if.field_end), 8'(want_tok.field_end));
          if (out_if.record_end !== want_tok.record_end)
            report_mismatch("record_end", 8'(out_if.record_end), 8'(want_tok.record_end));
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** csv_tokenizer: FAILED **");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic eot);
    text_bytes_q = {text_bytes_q, csvt_pkg::in_item_t'{data_byte: b, end_of_text: eot}};
    phase_bytes++;
  endtask

  // Append one byte to the text under construction
  task automatic add_byte(input logic [7:0] b);
    build_q = {build_q, b};
  endtask

  // Send the built text, marking its last byte as final when asked
  task automatic flush_text(input logic eot);
    for (int i = 0; i < build_q.size(); i++)
      put(build_q[i], eot && (i == build_q.size() - 1));
    build_q.delete();
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_COMMA ||
           b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = csvt_pkg::CH_COMMA;
      1: b = csvt_pkg::CH_CR;
      2: b = csvt_pkg::CH_LF;
      default: begin
        do b = 8'($urandom_range(255));
        while (b == csvt_pkg::CH_QUOTE);
      end
    endcase
    return b;
  endfunction

  // Append one field: plain, quoted, quoted with a tail, or left unterminated
  task automatic add_field();
    int kind;
    int len;
    kind = $urandom_range(9);
    len  = $urandom_range(5);
    if (kind < 5) begin
      for (int i = 0; i < len; i++)
        add_byte((i > 0 && $urandom_range(15) == 0) ? csvt_pkg::CH_QUOTE : plain_byte());
    end else begin
      add_byte(csvt_pkg::CH_QUOTE);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(5) == 0) begin
          add_byte(csvt_pkg::CH_QUOTE);
          add_byte(csvt_pkg::CH_QUOTE);
        end else begin
          add_byte(quoted_byte());
        end
      end
      if (kind != 9 || $urandom_range(1) == 0) add_byte(csvt_pkg::CH_QUOTE);
      if (kind == 8) add_byte(plain_byte());
    end
  endtask

  // Build one text of a few records, some fields malformed, and send it
  task automatic add_text();
    int n_rec;
    int n_fld;
    int term;
    n_rec = $urandom_range(1, 4);
    for (int r = 0; r < n_rec; r++) begin
      n_fld = $urandom_range(1, 4);
      for (int f = 0; f < n_fld; f++) begin
        if (f > 0) add_byte(csvt_pkg::CH_COMMA);
        add_field();
      end
      term = $urandom_range(3);
      if (term == 0 || term == 2) add_byte(csvt_pkg::CH_CR);
      if (term == 1 || term == 2) add_byte(csvt_pkg::CH_LF);
      if (term == 3 && r != n_rec - 1) add_byte(csvt_pkg::CH_CR);
    end
    if ($urandom_range(7) == 0) add_byte(csvt_pkg::CH_COMMA);
    if (build_q.size() == 0) add_byte(plain_byte());
    flush_text(1'b1);
  endtask

  // Send a short burst of arbitrary bytes, biased toward the special ones
  task automatic add_noise();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0: add_byte(csvt_pkg::CH_QUOTE);
        1: add_byte(csvt_pkg::CH_COMMA);
        2: add_byte(csvt_pkg::CH_CR);
        3: add_byte(csvt_pkg::CH_LF);
        default: add_byte(8'($urandom_range(255)));
      endcase
    end
    flush_text(1'($urandom_range(1)));
  endtask

  int idle_by_phase[4]  = '{0, 80, 0, 14};
  int stall_by_phase[4] = '{0, 0, 80, 14};

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_bytes    = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      phase_bytes    = 0;
      if (p == 0) begin
        // Extreme bytes, quote inside a plain field, CRLF pair
        put(8'h00, 1'b0);
        put(csvt_pkg::CH_COMMA, 1'b0);
        put(8'hFF, 1'b0);
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(csvt_pkg::CH_CR, 1'b0);
        put(csvt_pkg::CH_LF, 1'b0);
        // Comma and CR inside quotes, doubled quote, byte after closing quote
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(csvt_pkg::CH_COMMA, 1'b0);
        put(csvt_pkg::CH_CR, 1'b0);
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(8'h78, 1'b0);
        put(csvt_pkg::CH_LF, 1'b0);
        // Lone CR then content, trailing comma at end of text
        put(8'h61, 1'b0);
        put(csvt_pkg::CH_CR, 1'b0);
        put(8'h62, 1'b0);
        put(csvt_pkg::CH_COMMA, 1'b1);
        // Empty quoted field cut off by end of text
        put(csvt_pkg::CH_QUOTE, 1'b1);
        // Unterminated quoted field with content
        put(csvt_pkg::CH_QUOTE, 1'b0);
        put(8'h71, 1'b1);
        // Swallowed LF as the final byte
        put(8'h7A, 1'b0);
        put(csvt_pkg::CH_CR, 1'b0);
        put(csvt_pkg::CH_LF, 1'b1);
      end
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(6) == 0) add_noise();
        else add_text();
      end
      do @(posedge clk_i);
      while (text_bytes_q.size() != 0);
    end

    // Drain outstanding tokens, then allow for the pipeline latency
    do @(posedge clk_i);
    while (in_if.valid || token_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("** csv_tokenizer: PASSED **");
    end else begin
      $display("** csv_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
